>>> design/dvrt_pkg.sv
// shared constants, codes and controller/datapath interface types for the route table
package dvrt_pkg;

   // parameter defaults
   localparam int TABLE_DEPTH_DEFAULT = 64;
   localparam int PORT_COUNT_DEFAULT  = 8;

   // field widths
   localparam int ACTION_W   = 2;
   localparam int NODE_W     = 8;
   localparam int DIST_W     = 8;
   localparam int PORT_W     = 3;
   localparam int INDEX_W    = 6;
   localparam int COUNT_W    = 7;
   localparam int OUTCOME_W  = 3;
   localparam int CFG_W      = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int ENTRY_W    = NODE_W + DIST_W + NODE_W + PORT_W;

   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   // own node address step per router
   localparam int NODES_PER_ROUTER = 10;

   // request actions
   localparam logic [ACTION_W-1:0] ACT_UPDATE  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_REFRESH = 2'd1;

   // result outcomes
   localparam logic [OUTCOME_W-1:0] OUT_REPLACED   = 3'd0;
   localparam logic [OUTCOME_W-1:0] OUT_KEPT       = 3'd1;
   localparam logic [OUTCOME_W-1:0] OUT_ADDED      = 3'd2;
   localparam logic [OUTCOME_W-1:0] OUT_IGNORED    = 3'd3;
   localparam logic [OUTCOME_W-1:0] OUT_FULL       = 3'd4;
   localparam logic [OUTCOME_W-1:0] OUT_REFRESHED  = 3'd5;
   localparam logic [OUTCOME_W-1:0] OUT_READ_OK    = 3'd6;
   localparam logic [OUTCOME_W-1:0] OUT_READ_EMPTY = 3'd7;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LOCAL_ID  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_COUNT = 1'd1;

   // reset values of the configuration registers
   localparam logic [CFG_W-1:0] LOCAL_ID_RESET  = 4'd1;
   localparam logic [CFG_W-1:0] OWN_COUNT_RESET = 4'd0;

   // table read address source
   typedef enum logic [1:0] {
      RD_NEXT,
      RD_ZERO,
      RD_RIDX
   } rd_sel_type;

   // entry fields shown in the result
   typedef enum logic [1:0] {
      SHOW_ZERO,
      SHOW_RAM,
      SHOW_NEW
   } show_sel_type;

   // entry index shown in the result
   typedef enum logic [1:0] {
      ISEL_ZERO,
      ISEL_IDX,
      ISEL_COUNT,
      ISEL_RIDX
   } idx_sel_type;

   typedef struct packed {
      logic                 load;
      logic                 clr_idx;
      logic                 inc_idx;
      logic                 ref_wr;
      logic                 upd_wr;
      logic                 app_wr;
      logic                 set_count_ref;
      rd_sel_type           rd_sel;
      logic                 rsp;
      logic [OUTCOME_W-1:0] outcome;
      show_sel_type         show;
      idx_sel_type          idx_sel;
   } dvrt_cmd_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic                dest_zero;
      logic                count_zero;
      logic                ref_empty;
      logic                ref_last;
      logic                hit;
      logic                closer;
      logic                scan_last;
      logic                full;
      logic                read_ok;
   } dvrt_sts_type;

endpackage

>>> design/dvrt_ram.sv
// generic single write port ram with registered read
module dvrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/dvrt_ctrl.sv
// controller state machine for the route table
module dvrt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  dvrt_pkg::dvrt_sts_type sts,
   output dvrt_pkg::dvrt_cmd_type cmd,
   output logic                  busy
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DISPATCH = 3'd1;
   localparam logic [2:0] S_READ     = 3'd2;
   localparam logic [2:0] S_SCAN     = 3'd3;
   localparam logic [2:0] S_REFRESH  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            priority if (sts.action == dvrt_pkg::ACT_REFRESH) begin
               cmd.clr_idx = 1'b1;
               if (sts.ref_empty) begin
                  cmd.set_count_ref = 1'b1;
                  cmd.rsp           = 1'b1;
                  cmd.outcome       = dvrt_pkg::OUT_REFRESHED;
                  state_in          = S_IDLE;
               end else begin
                  state_in = S_REFRESH;
               end
            end else if (sts.action == dvrt_pkg::ACT_UPDATE) begin
               priority if (sts.dest_zero) begin
                  cmd.rsp     = 1'b1;
                  cmd.outcome = dvrt_pkg::OUT_IGNORED;
                  state_in    = S_IDLE;
               end else if (sts.count_zero) begin
                  // empty table: append at once
                  cmd.app_wr  = 1'b1;
                  cmd.rsp     = 1'b1;
                  cmd.outcome = dvrt_pkg::OUT_ADDED;
                  cmd.show    = dvrt_pkg::SHOW_NEW;
                  cmd.idx_sel = dvrt_pkg::ISEL_COUNT;
                  state_in    = S_IDLE;
               end else begin
                  cmd.clr_idx = 1'b1;
                  cmd.rd_sel  = dvrt_pkg::RD_ZERO;
                  state_in    = S_SCAN;
               end
            end else begin
               cmd.rd_sel = dvrt_pkg::RD_RIDX;
               state_in   = S_READ;
            end
         end
         S_READ: begin
            cmd.rsp     = 1'b1;
            cmd.idx_sel = dvrt_pkg::ISEL_RIDX;
            if (sts.read_ok) begin
               cmd.outcome = dvrt_pkg::OUT_READ_OK;
               cmd.show    = dvrt_pkg::SHOW_RAM;
            end else begin
               cmd.outcome = dvrt_pkg::OUT_READ_EMPTY;
            end
            state_in = S_IDLE;
         end
         S_SCAN: begin
            cmd.rd_sel = dvrt_pkg::RD_NEXT;
            priority if (sts.hit) begin
               cmd.rsp     = 1'b1;
               cmd.idx_sel = dvrt_pkg::ISEL_IDX;
               if (sts.closer) begin
                  cmd.upd_wr  = 1'b1;
                  cmd.outcome = dvrt_pkg::OUT_REPLACED;
                  cmd.show    = dvrt_pkg::SHOW_NEW;
               end else begin
                  cmd.outcome = dvrt_pkg::OUT_KEPT;
                  cmd.show    = dvrt_pkg::SHOW_RAM;
               end
               state_in = S_IDLE;
            end else if (sts.scan_last) begin
               cmd.rsp = 1'b1;
               if (sts.full) begin
                  cmd.outcome = dvrt_pkg::OUT_FULL;
               end else begin
                  cmd.app_wr  = 1'b1;
                  cmd.outcome = dvrt_pkg::OUT_ADDED;
                  cmd.show    = dvrt_pkg::SHOW_NEW;
                  cmd.idx_sel = dvrt_pkg::ISEL_COUNT;
               end
               state_in = S_IDLE;
            end else begin
               cmd.inc_idx = 1'b1;
            end
         end
         S_REFRESH: begin
            cmd.ref_wr  = 1'b1;
            cmd.inc_idx = 1'b1;
            if (sts.ref_last) begin
               cmd.set_count_ref = 1'b1;
               cmd.rsp           = 1'b1;
               cmd.outcome       = dvrt_pkg::OUT_REFRESHED;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

endmodule

>>> design/dvrt_dpath.sv
// datapath: request and config registers, route ram, counters and result registers
module dvrt_dpath #(
   parameter int TABLE_DEPTH = dvrt_pkg::TABLE_DEPTH_DEFAULT,
   parameter int PORT_COUNT  = dvrt_pkg::PORT_COUNT_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  dvrt_pkg::dvrt_cmd_type            cmd,
   output dvrt_pkg::dvrt_sts_type            sts,
   input  logic                              csr_write,
   input  logic [dvrt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dvrt_pkg::CFG_W-1:0]        csr_wdata,
   input  logic [dvrt_pkg::ACTION_W-1:0]     req_action,
   input  logic [dvrt_pkg::NODE_W-1:0]       req_dest_address,
   input  logic [dvrt_pkg::DIST_W-1:0]       req_advertised_distance,
   input  logic [dvrt_pkg::NODE_W-1:0]       req_neighbor_router,
   input  logic [dvrt_pkg::PORT_W-1:0]       req_port_index,
   input  logic [dvrt_pkg::INDEX_W-1:0]      req_read_index,
   output logic                              rsp_valid,
   output logic [dvrt_pkg::OUTCOME_W-1:0]    rsp_outcome,
   output logic [dvrt_pkg::INDEX_W-1:0]      rsp_entry_index,
   output logic [dvrt_pkg::NODE_W-1:0]       rsp_entry_address,
   output logic [dvrt_pkg::DIST_W-1:0]       rsp_entry_distance,
   output logic [dvrt_pkg::NODE_W-1:0]       rsp_entry_next_hop,
   output logic [dvrt_pkg::PORT_W-1:0]       rsp_entry_port,
   output logic [dvrt_pkg::COUNT_W-1:0]      rsp_entry_count
);

   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int WIDE_W = CNT_W + dvrt_pkg::INDEX_W;
   localparam int NODE_W = dvrt_pkg::NODE_W;
   localparam int DIST_W = dvrt_pkg::DIST_W;
   localparam int PORT_W = dvrt_pkg::PORT_W;

   // configuration
   logic [dvrt_pkg::CFG_W-1:0] local_id_ff;
   logic [dvrt_pkg::CFG_W-1:0] own_count_ff;

   // latched request
   logic [dvrt_pkg::ACTION_W-1:0] action_ff;
   logic [NODE_W-1:0]             dest_ff;
   logic [DIST_W-1:0]             adv_ff;
   logic [NODE_W-1:0]             nbr_ff;
   logic [PORT_W-1:0]             port_ff;
   logic [dvrt_pkg::INDEX_W-1:0]  ridx_ff;

   // counters
   logic [IDX_W-1:0]  idx_ff;
   logic [IDX_W-1:0]  idx_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [CNT_W-1:0]  own_n_ff;
   logic [CNT_W-1:0]  own_n_in;
   logic [NODE_W-1:0] own_addr_ff;
   logic [NODE_W-1:0] own_addr_in;

   // result registers
   logic                           rsp_valid_ff;
   logic [dvrt_pkg::OUTCOME_W-1:0] rsp_outcome_ff;
   logic [dvrt_pkg::INDEX_W-1:0]   rsp_index_ff;
   logic [NODE_W-1:0]              rsp_address_ff;
   logic [DIST_W-1:0]              rsp_distance_ff;
   logic [NODE_W-1:0]              rsp_next_hop_ff;
   logic [PORT_W-1:0]              rsp_port_ff;
   logic [dvrt_pkg::COUNT_W-1:0]   rsp_count_ff;

   // ram
   logic                         wr_en;
   logic [IDX_W-1:0]             wr_addr;
   logic [dvrt_pkg::ENTRY_W-1:0] wr_data;
   logic [IDX_W-1:0]             rd_addr;
   logic [dvrt_pkg::ENTRY_W-1:0] rd_data;

   logic [NODE_W-1:0] rd_address;
   logic [DIST_W-1:0] rd_distance;
   logic [NODE_W-1:0] rd_next_hop;
   logic [PORT_W-1:0] rd_port;

   logic [DIST_W-1:0] new_dist;
   logic [PORT_W-1:0] port_stored;
   logic [NODE_W-1:0] rid_wide;
   logic [WIDE_W-1:0] ridx_wide;
   logic [WIDE_W-1:0] count_wide;
   logic [WIDE_W-1:0] count_in_wide;
   logic [WIDE_W-1:0] own_wide;
   logic [CNT_W-1:0]  idx_next;
   logic [WIDE_W-1:0] index_sel;
   logic              read_ok;

   assign {rd_address, rd_distance, rd_next_hop, rd_port} = rd_data;

   assign new_dist    = (adv_ff == dvrt_pkg::DIST_MAX) ? dvrt_pkg::DIST_MAX
                                                       : adv_ff + DIST_W'(1);
   assign port_stored = ({4'd0, port_ff} >= 7'(PORT_COUNT)) ? PORT_W'(PORT_COUNT - 1)
                                                            : port_ff;
   assign rid_wide    = NODE_W'(local_id_ff);
   assign ridx_wide   = WIDE_W'(ridx_ff);
   assign count_wide  = WIDE_W'(count_ff);
   assign own_wide    = WIDE_W'(own_count_ff);
   assign idx_next    = CNT_W'(idx_ff) + CNT_W'(1);
   assign read_ok     = (ridx_wide < count_wide);

   // own node count saturates at the table depth
   assign own_n_in = (own_wide > WIDE_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                       : CNT_W'(own_count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         local_id_ff  <= dvrt_pkg::LOCAL_ID_RESET;
         own_count_ff <= dvrt_pkg::OWN_COUNT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            dvrt_pkg::CSR_LOCAL_ID:  local_id_ff  <= csr_wdata;
            dvrt_pkg::CSR_OWN_COUNT: own_count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff   <= req_action;
         dest_ff     <= req_dest_address;
         adv_ff      <= req_advertised_distance;
         nbr_ff      <= req_neighbor_router;
         port_ff     <= req_port_index;
         ridx_ff     <= req_read_index;
         own_n_ff    <= own_n_in;
      end
      own_addr_ff <= own_addr_in;
   end

   // own address starts at local_id * 10 and steps by one per refresh write
   always_comb begin
      own_addr_in = own_addr_ff;
      if (cmd.load) begin
         own_addr_in = (rid_wide << 3) + (rid_wide << 1);
      end else if (cmd.ref_wr) begin
         own_addr_in = own_addr_ff + NODE_W'(1);
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.clr_idx) begin
         idx_in = '0;
      end else if (cmd.inc_idx) begin
         idx_in = idx_next[IDX_W-1:0];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.set_count_ref) begin
         count_in = own_n_ff;
      end else if (cmd.app_wr) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         count_ff <= '0;
      end else begin
         idx_ff   <= idx_in;
         count_ff <= count_in;
      end
   end

   // ram ports
   assign wr_en   = cmd.ref_wr | cmd.upd_wr | cmd.app_wr;
   assign wr_addr = cmd.app_wr ? count_ff[IDX_W-1:0] : idx_ff;
   assign wr_data = cmd.ref_wr ? {own_addr_ff, DIST_W'(0), own_addr_ff, PORT_W'(0)}
                               : {dest_ff, new_dist, nbr_ff, port_stored};

   always_comb begin
      unique case (cmd.rd_sel)
         dvrt_pkg::RD_ZERO: rd_addr = '0;
         dvrt_pkg::RD_RIDX: rd_addr = read_ok ? ridx_wide[IDX_W-1:0] : '0;
         // look one entry ahead so the data lines up with idx_ff
         default: rd_addr = (idx_next == CNT_W'(TABLE_DEPTH)) ? '0
                                                             : idx_next[IDX_W-1:0];
      endcase
   end

   dvrt_ram #(
      .WIDTH(dvrt_pkg::ENTRY_W),
      .DEPTH(TABLE_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // status
   assign sts.action     = action_ff;
   assign sts.dest_zero  = (dest_ff == '0);
   assign sts.count_zero = (count_ff == '0);
   assign sts.ref_empty  = (own_n_ff == '0);
   assign sts.ref_last   = (CNT_W'(idx_ff) == own_n_ff - CNT_W'(1));
   assign sts.hit        = (rd_address == dest_ff);
   assign sts.closer     = (new_dist < rd_distance);
   assign sts.scan_last  = (idx_next == count_ff);
   assign sts.full       = (count_ff == CNT_W'(TABLE_DEPTH));
   assign sts.read_ok    = read_ok;

   // result
   always_comb begin
      unique case (cmd.idx_sel)
         dvrt_pkg::ISEL_IDX:   index_sel = WIDE_W'(idx_ff);
         dvrt_pkg::ISEL_COUNT: index_sel = count_wide;
         dvrt_pkg::ISEL_RIDX:  index_sel = ridx_wide;
         default:              index_sel = '0;
      endcase
   end

   assign count_in_wide = WIDE_W'(count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp) begin
         rsp_outcome_ff <= cmd.outcome;
         rsp_index_ff   <= index_sel[dvrt_pkg::INDEX_W-1:0];
         rsp_count_ff   <= count_in_wide[dvrt_pkg::COUNT_W-1:0];
         unique case (cmd.show)
            dvrt_pkg::SHOW_RAM: begin
               rsp_address_ff  <= rd_address;
               rsp_distance_ff <= rd_distance;
               rsp_next_hop_ff <= rd_next_hop;
               rsp_port_ff     <= rd_port;
            end
            dvrt_pkg::SHOW_NEW: begin
               rsp_address_ff  <= dest_ff;
               rsp_distance_ff <= new_dist;
               rsp_next_hop_ff <= nbr_ff;
               rsp_port_ff     <= port_stored;
            end
            default: begin
               rsp_address_ff  <= '0;
               rsp_distance_ff <= '0;
               rsp_next_hop_ff <= '0;
               rsp_port_ff     <= '0;
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_outcome        = rsp_outcome_ff;
   assign rsp_entry_index    = rsp_index_ff;
   assign rsp_entry_address  = rsp_address_ff;
   assign rsp_entry_distance = rsp_distance_ff;
   assign rsp_entry_next_hop = rsp_next_hop_ff;
   assign rsp_entry_port     = rsp_port_ff;
   assign rsp_entry_count    = rsp_count_ff;

endmodule

>>> design/distance_vector_route_table.sv
// top level of the distance-vector route table
//
// usage
// - a request is taken at a clock edge with start high and busy low; req_action picks
//   a route update, a refresh back to the own node entries, or an entry read
// - every request gives exactly one result, shown for one cycle with rsp_valid high;
//   the receiver cannot stall, so it must take the result in that cycle
// - an ignored update or an append to an empty table is answered from the dispatch
//   state, a read from the read state after dispatch, a refresh after writing all
//   own entries, and an update once its scan hits the destination or reaches the last entry
// - the route table ram has one read and one write port; the scan reads one entry
//   per cycle and refresh writes one own entry per cycle
// - busy drops in the result cycle, so the next request can follow right away
// - csr_write with csr_index/csr_wdata sets the local router number and
//   own_node_count; write only while the block is idle
// - reset empties the table (entry count zero) and loads local router number 1 and
//   own_node_count 0; the ram contents are not cleared, and a refresh loads the own
//   entries
module distance_vector_route_table #(
   parameter int TABLE_DEPTH = dvrt_pkg::TABLE_DEPTH_DEFAULT,
   parameter int PORT_COUNT  = dvrt_pkg::PORT_COUNT_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // request
   input  logic                            start,
   output logic                            busy,
   input  logic [dvrt_pkg::ACTION_W-1:0]   req_action,
   input  logic [dvrt_pkg::NODE_W-1:0]     req_dest_address,
   input  logic [dvrt_pkg::DIST_W-1:0]     req_advertised_distance,
   input  logic [dvrt_pkg::NODE_W-1:0]     req_neighbor_router,
   input  logic [dvrt_pkg::PORT_W-1:0]     req_port_index,
   input  logic [dvrt_pkg::INDEX_W-1:0]    req_read_index,
   // result
   output logic                            rsp_valid,
   output logic [dvrt_pkg::OUTCOME_W-1:0]  rsp_outcome,
   output logic [dvrt_pkg::INDEX_W-1:0]    rsp_entry_index,
   output logic [dvrt_pkg::NODE_W-1:0]     rsp_entry_address,
   output logic [dvrt_pkg::DIST_W-1:0]     rsp_entry_distance,
   output logic [dvrt_pkg::NODE_W-1:0]     rsp_entry_next_hop,
   output logic [dvrt_pkg::PORT_W-1:0]     rsp_entry_port,
   output logic [dvrt_pkg::COUNT_W-1:0]    rsp_entry_count,
   // configuration
   input  logic                            csr_write,
   input  logic [dvrt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dvrt_pkg::CFG_W-1:0]      csr_wdata
);

   // command and status between controller and datapath
   dvrt_pkg::dvrt_cmd_type cmd;
   dvrt_pkg::dvrt_sts_type sts;

   // sequencing: dispatch, scan, refresh and read steps
   dvrt_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .sts  (sts),
      .cmd  (cmd),
      .busy (busy)
   );

   // table storage, counters and result registers
   dvrt_dpath #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .PORT_COUNT (PORT_COUNT)
   ) u_dpath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .sts                    (sts),
      .csr_write              (csr_write),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .req_action             (req_action),
      .req_dest_address       (req_dest_address),
      .req_advertised_distance(req_advertised_distance),
      .req_neighbor_router    (req_neighbor_router),
      .req_port_index         (req_port_index),
      .req_read_index         (req_read_index),
      .rsp_valid              (rsp_valid),
      .rsp_outcome            (rsp_outcome),
      .rsp_entry_index        (rsp_entry_index),
      .rsp_entry_address      (rsp_entry_address),
      .rsp_entry_distance     (rsp_entry_distance),
      .rsp_entry_next_hop     (rsp_entry_next_hop),
      .rsp_entry_port         (rsp_entry_port),
      .rsp_entry_count        (rsp_entry_count)
   );

   // a request transfer always moves the controller out of idle
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request transfer did not make the block busy");

   // the controller returns to idle after each result, so results never come back to back
   a_rsp_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two results in consecutive cycles");

   // issuing a result ends the request
   a_rsp_ends: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp |=> (!busy && rsp_valid))
      else $error("result issued but request not finished");

   // the single ram write port is claimed by one source at a time
   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.ref_wr, cmd.upd_wr, cmd.app_wr}))
      else $error("more than one table write in a cycle");

endmodule
